FILE: design/fct_pkg.sv
// Package for the frustum cull test: fixed-point widths, the item beat
// and the control structs handed along the chain of plane cells.
// No dependencies.
`default_nettype none

package fct_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int NUM_PLANES   = 6;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int COMP_W       = 16;
   localparam int FRAC_ALIGN_W = 22;
   localparam int FRAC_ALIGN_R = 14;

   // normal component times coordinate
   localparam int PROD_W  = COORD_WIDTH + COMP_W;
   localparam int BIAS_W  = COMP_W + FRAC_ALIGN_W;
   localparam int SUM_MAX = (PROD_W + 2 > BIAS_W) ? PROD_W + 2 : BIAS_W;
   // three products, plane distance and radius, never overflows
   localparam int ACC_W   = SUM_MAX + 3;

   // input register plus two stages per cell
   localparam int LATENCY = 1 + 2 * NUM_PLANES;

   localparam logic KIND_BOX    = 1'b0;
   localparam logic KIND_SPHERE = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic signed [COORD_WIDTH-1:0] box_min_x;
      logic signed [COORD_WIDTH-1:0] box_min_y;
      logic signed [COORD_WIDTH-1:0] box_min_z;
      logic signed [COORD_WIDTH-1:0] box_max_x;
      logic signed [COORD_WIDTH-1:0] box_max_y;
      logic signed [COORD_WIDTH-1:0] box_max_z;
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic signed [COORD_WIDTH-1:0] center_z;
      logic        [COORD_WIDTH-2:0] radius;
   } item_type;

   typedef struct packed {
      logic valid;
      logic visible;
   } ctl_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_DATA_W-1:0] data;
   } plane_wr_type;

endpackage

`default_nettype wire

FILE: design/fct_cell.sv
// One plane cell of the culling chain: holds a plane, tests the passing
// beat against it and ANDs the outcome into the running visible flag.
// Depends on fct_pkg.
`default_nettype none

module fct_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fct_pkg::plane_wr_type plane_wr,
   input  wire fct_pkg::ctl_type      ctl_in,
   input  wire fct_pkg::item_type     item_in,
   output fct_pkg::ctl_type           ctl_out,
   output fct_pkg::item_type          item_out
);

   logic [fct_pkg::CSR_DATA_W-1:0] plane_ff;

   logic signed [fct_pkg::COMP_W-1:0] nx, ny, nz, w;
   logic signed [fct_pkg::COORD_WIDTH-1:0] px, py, pz;
   logic sphere;

   logic signed [fct_pkg::PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [fct_pkg::PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [fct_pkg::ACC_W-1:0]  w_term, r_term, bias_in, bias_ff;
   logic signed [fct_pkg::ACC_W-1:0]  acc;

   fct_pkg::item_type item_a_ff, item_b_ff;
   fct_pkg::ctl_type  ctl_a_ff, ctl_b_ff, ctl_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (plane_wr.we) begin
         plane_ff <= plane_wr.data;
      end
   end

   assign nx = plane_ff[15:0];
   assign ny = plane_ff[31:16];
   assign nz = plane_ff[47:32];
   assign w  = plane_ff[63:48];

   // stage A: pick the test point, multiply, form distance plus radius
   always_comb begin
      sphere = (item_in.kind == fct_pkg::KIND_SPHERE);
      if (sphere) begin
         px = item_in.center_x;
         py = item_in.center_y;
         pz = item_in.center_z;
      end else begin
         // positive vertex: max corner unless the normal points negative
         px = nx[fct_pkg::COMP_W-1] ? item_in.box_min_x : item_in.box_max_x;
         py = ny[fct_pkg::COMP_W-1] ? item_in.box_min_y : item_in.box_max_y;
         pz = nz[fct_pkg::COMP_W-1] ? item_in.box_min_z : item_in.box_max_z;
      end
      prod_x_in = nx * px;
      prod_y_in = ny * py;
      prod_z_in = nz * pz;
      w_term    = fct_pkg::ACC_W'(w) <<< fct_pkg::FRAC_ALIGN_W;
      r_term    = sphere ?
                  (fct_pkg::ACC_W'({1'b0, item_in.radius}) <<< fct_pkg::FRAC_ALIGN_R) :
                  '0;
      bias_in   = w_term + r_term;
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      bias_ff   <= bias_in;
      item_a_ff <= item_in;
      if (reset) begin
         ctl_a_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_in;
      end
   end

   // stage B: sum and sign test (sphere: d + r >= 0)
   always_comb begin
      acc = fct_pkg::ACC_W'(prod_x_ff) + fct_pkg::ACC_W'(prod_y_ff)
          + fct_pkg::ACC_W'(prod_z_ff) + bias_ff;
      ctl_b_in.valid   = ctl_a_ff.valid;
      ctl_b_in.visible = ctl_a_ff.visible & ~acc[fct_pkg::ACC_W-1];
   end

   always_ff @(posedge clock) begin
      item_b_ff <= item_a_ff;
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_b_in;
      end
   end

   assign ctl_out  = ctl_b_ff;
   assign item_out = item_b_ff;

   a_plane_write: assert property (@(posedge clock) disable iff (reset)
      plane_wr.we |=> plane_ff == $past(plane_wr.data))
      else $error("plane register missed a write");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      ctl_b_ff.valid |-> $past(ctl_in.valid, 2))
      else $error("beat left the cell without entering it");

   a_flag_only_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl_b_ff.valid && ctl_b_ff.visible) |-> $past(ctl_in.visible, 2))
      else $error("visible flag set inside a cell");

endmodule

`default_nettype wire

FILE: design/frustum_cull_test.sv
// Frustum cull test top level: input register, chain of plane cells and
// the plane register write port. Depends on fct_pkg and fct_cell.
//
// Use: software loads the six planes (left, right, bottom, top, near, far)
// through the csr_ channel, index 0..5, while no test is in flight; each
// beat holds nx, ny, nz in Q1.14 (bits 0-47) and w in bits 48-63. A write
// to index 6 or 7 is dropped. csr_ready is always high.
// A test is issued by raising start with the req_ fields; busy stays low,
// so one test may be issued every cycle. Each test yields one rsp_valid
// strobe with rsp_visible, passing in order through the input register
// and then two stages (multiply, sum and sign) in each of the six plane
// cells. Results leave in issue order, one per cycle at most.
// The receiver cannot stall the response; it must take the strobe.
// Reset clears all planes to zero (every volume then reads visible) and
// drops any tests in flight.
`default_nettype none

module frustum_cull_test (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic                                   req_kind,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_min_x,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_min_y,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_min_z,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_max_x,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_max_y,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_box_max_z,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_center_x,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_center_y,
   input  wire logic signed [fct_pkg::COORD_WIDTH-1:0] req_center_z,
   input  wire logic        [fct_pkg::COORD_WIDTH-2:0] req_radius,
   output logic                                        rsp_valid,
   output logic                                        rsp_visible,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [fct_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [fct_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   fct_pkg::item_type in_item_ff;
   fct_pkg::ctl_type  in_ctl_ff;

   fct_pkg::item_type     item_chain [fct_pkg::NUM_PLANES+1];
   fct_pkg::ctl_type      ctl_chain  [fct_pkg::NUM_PLANES+1];
   fct_pkg::plane_wr_type plane_wr   [fct_pkg::NUM_PLANES];

   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      in_item_ff.kind      <= req_kind;
      in_item_ff.box_min_x <= req_box_min_x;
      in_item_ff.box_min_y <= req_box_min_y;
      in_item_ff.box_min_z <= req_box_min_z;
      in_item_ff.box_max_x <= req_box_max_x;
      in_item_ff.box_max_y <= req_box_max_y;
      in_item_ff.box_max_z <= req_box_max_z;
      in_item_ff.center_x  <= req_center_x;
      in_item_ff.center_y  <= req_center_y;
      in_item_ff.center_z  <= req_center_z;
      in_item_ff.radius    <= req_radius;
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff.valid   <= accept;
         in_ctl_ff.visible <= 1'b1;
      end
   end

   assign item_chain[0] = in_item_ff;
   assign ctl_chain[0]  = in_ctl_ff;

   for (genvar i = 0; i < fct_pkg::NUM_PLANES; i++) begin : g_cell
      assign plane_wr[i].we   = csr_valid && csr_ready
                                && (csr_index == fct_pkg::CSR_IDX_W'(i));
      assign plane_wr[i].data = csr_wdata;

      fct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .plane_wr (plane_wr[i]),
         .ctl_in   (ctl_chain[i]),
         .item_in  (item_chain[i]),
         .ctl_out  (ctl_chain[i+1]),
         .item_out (item_chain[i+1])
      );
   end

   assign rsp_valid   = ctl_chain[fct_pkg::NUM_PLANES].valid;
   assign rsp_visible = ctl_chain[fct_pkg::NUM_PLANES].visible;

   a_issue_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(fct_pkg::LATENCY) rsp_valid)
      else $error("issued test produced no response");

   a_rsp_from_issue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, fct_pkg::LATENCY))
      else $error("response without an issued test");

endmodule

`default_nettype wire
